### design/rbsi_pkg.sv
// Shared types, constants and helpers for the ray/box slab intersection block.
// Depends on nothing; every design module imports it.
package rbsi_pkg;

	typedef logic signed [31:0] s32_t;
	typedef logic signed [32:0] s33_t;
	typedef logic signed [63:0] s64_t;
	typedef logic signed [64:0] s65_t;

	localparam s32_t S32_MAX = 32'sh7FFF_FFFF;
	localparam s32_t S32_MIN = 32'sh8000_0000;

	// reciprocal divider: 2^32 / |d|, restoring, STEP quotient bits per stage
	localparam int unsigned NQ   = 36;
	localparam int unsigned STEP = 4;
	localparam int unsigned NST  = NQ / STEP;
	localparam logic [NQ-1:0] DIVIDEND = 36'h1_0000_0000;

	// word carried alongside the reciprocal
	typedef struct packed {
		s32_t [2:0] o;
		s32_t [2:0] d;
		s33_t [2:0] dlo;
		s33_t [2:0] dhi;
		logic       in_box;
	} side_t;

	// one reciprocal lane
	typedef struct packed {
		logic [31:0] den;
		logic        neg;
		logic        zero;
	} lane_t;

	typedef struct packed {
		logic [31:0]   rem;
		logic [NQ-1:0] quo;
	} div_t;

	// word handed from the slab stages to the point stages
	typedef struct packed {
		s32_t [2:0] o;
		s32_t [2:0] d;
		logic       in_box;
		s32_t       nearb;
		s32_t       farb;
	} bound_t;

	// saturate a wide signed value to 32 bits
	function automatic s32_t sat32(input s65_t v);
		s32_t r;
		if (v > 65'sh0_0000_0000_7FFF_FFFF) begin
			r = S32_MAX;
		end else if (v < 65'sh1_FFFF_FFFF_8000_0000) begin
			r = S32_MIN;
		end else begin
			r = s32_t'(v[31:0]);
		end
		return r;
	endfunction

	// saturating negation
	function automatic s32_t neg32(input s32_t v);
		s32_t r;
		if (v == S32_MIN) begin
			r = S32_MAX;
		end else begin
			r = -v;
		end
		return r;
	endfunction

	// STEP restoring division steps
	function automatic div_t div_step(input div_t cur, input logic [31:0] den,
			input logic [STEP-1:0] nb);
		div_t        r;
		logic [32:0] t;
		r = cur;
		for (int j = STEP - 1; j >= 0; j--) begin
			t = {r.rem, nb[j]};
			if (t >= {1'b0, den}) begin
				t = t - {1'b0, den};
				r.quo = {r.quo[NQ-2:0], 1'b1};
			end else begin
				r.quo = {r.quo[NQ-2:0], 1'b0};
			end
			r.rem = t[31:0];
		end
		return r;
	endfunction

endpackage

### design/rbsi_in_if.sv
// Input channel: one ray and one box per word, valid/ready handshake.
// Depends on nothing.
interface rbsi_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] origin_x;
	logic [31:0] origin_y;
	logic [31:0] origin_z;
	logic [31:0] dir_x;
	logic [31:0] dir_y;
	logic [31:0] dir_z;
	logic [31:0] box_min_x;
	logic [31:0] box_min_y;
	logic [31:0] box_min_z;
	logic [31:0] box_max_x;
	logic [31:0] box_max_y;
	logic [31:0] box_max_z;

	modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
		box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z, input ready);
	modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
		box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z, output ready);
endinterface

### design/rbsi_out_if.sv
// Output channel: hit flag, entry distance and entry point per word.
// Depends on nothing.
interface rbsi_out_if;
	logic        valid;
	logic        ready;
	logic        hit;
	logic [31:0] distance;
	logic [31:0] point_x;
	logic [31:0] point_y;
	logic [31:0] point_z;

	modport source (output valid, hit, distance, point_x, point_y, point_z, input ready);
	modport sink (input valid, hit, distance, point_x, point_y, point_z, output ready);
endinterface

### design/rbsi_prep.sv
// Front stage: inside test, direction reversal, slab differences, divisor set-up.
// Depends on rbsi_pkg.
module rbsi_prep (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  rbsi_pkg::s32_t [2:0]        o,
	input  rbsi_pkg::s32_t [2:0]        d,
	input  rbsi_pkg::s32_t [2:0]        lo,
	input  rbsi_pkg::s32_t [2:0]        hi,
	output logic                        out_valid,
	input  logic                        out_ready,
	output rbsi_pkg::side_t             side,
	output rbsi_pkg::lane_t [2:0]       lanes
);
	import rbsi_pkg::*;

	logic         v_s1;
	logic         en;
	logic         in_box;
	side_t        side_d;
	lane_t [2:0]  lanes_d;
	s32_t  [2:0]  dr;

	assign en       = !v_s1 || out_ready;
	assign in_ready = en;

	// origin strictly inside on every axis
	always_comb begin
		in_box = 1'b1;
		for (int i = 0; i < 3; i++) begin
			if (!($signed(o[i]) > $signed(lo[i]) && $signed(o[i]) < $signed(hi[i]))) begin
				in_box = 1'b0;
			end
		end
	end

	// reversed direction, differences and divisor magnitude per axis
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dr[i] = in_box ? neg32(d[i]) : d[i];
			side_d.o[i]   = o[i];
			side_d.d[i]   = dr[i];
			side_d.dlo[i] = s33_t'($signed(lo[i])) - s33_t'($signed(o[i]));
			side_d.dhi[i] = s33_t'($signed(hi[i])) - s33_t'($signed(o[i]));
			lanes_d[i].neg  = dr[i][31];
			lanes_d[i].zero = (dr[i] == '0);
			lanes_d[i].den  = dr[i][31] ? 32'(-dr[i]) : 32'(dr[i]);
		end
		side_d.in_box = in_box;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side  <= side_d;
			lanes <= lanes_d;
		end
	end

	assign out_valid = v_s1;
endmodule

### design/rbsi_recip.sv
// Pipelined restoring divider for 2^32 / |d| on three lanes, STEP bits a stage.
// Depends on rbsi_pkg; carries the side word along unchanged.
module rbsi_recip (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  rbsi_pkg::side_t             side_in,
	input  rbsi_pkg::lane_t [2:0]       lanes_in,
	output logic                        out_valid,
	input  logic                        out_ready,
	output rbsi_pkg::side_t             side_out,
	output rbsi_pkg::lane_t [2:0]       lanes_out,
	output rbsi_pkg::div_t  [2:0]       quo_out
);
	import rbsi_pkg::*;

	logic  [NST-1:0]          v_s;
	logic  [NST:0]            en;
	side_t                    side_s  [NST];
	lane_t [2:0]              lane_s  [NST];
	div_t  [2:0]              div_s   [NST];

	assign en[NST]  = out_ready;
	assign in_ready = en[0];

	genvar k;
	generate
		for (k = 0; k < NST; k++) begin : g_st
			localparam logic [STEP-1:0] NB = DIVIDEND[NQ-1-STEP*k -: STEP];
			div_t  [2:0] cur;
			div_t  [2:0] nxt;
			lane_t [2:0] ln;
			side_t       sd;
			logic        vin;

			assign en[k] = !v_s[k] || en[k+1];

			// source of this stage
			if (k == 0) begin : g_first
				assign vin = in_valid;
				assign ln  = lanes_in;
				assign sd  = side_in;
				assign cur = '0;
			end else begin : g_rest
				assign vin = v_s[k-1];
				assign ln  = lane_s[k-1];
				assign sd  = side_s[k-1];
				assign cur = div_s[k-1];
			end

			always_comb begin
				for (int i = 0; i < 3; i++) begin
					nxt[i] = div_step(cur[i], ln[i].den, NB);
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s[k] <= 1'b0;
				end else if (en[k]) begin
					v_s[k] <= vin;
				end
			end

			always_ff @(posedge clk) begin
				if (en[k]) begin
					div_s[k]  <= nxt;
					lane_s[k] <= ln;
					side_s[k] <= sd;
				end
			end
		end
	endgenerate

	assign out_valid = v_s[NST-1];
	assign side_out  = side_s[NST-1];
	assign lanes_out = lane_s[NST-1];
	assign quo_out   = div_s[NST-1];
endmodule

### design/rbsi_slab.sv
// Slab stages: reciprocal finish, six products, slab distances, near/far bounds.
// Depends on rbsi_pkg.
module rbsi_slab (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  rbsi_pkg::side_t             side,
	input  rbsi_pkg::lane_t [2:0]       lanes,
	input  rbsi_pkg::div_t  [2:0]       quo,
	output logic                        out_valid,
	input  logic                        out_ready,
	output rbsi_pkg::bound_t            bound
);
	import rbsi_pkg::*;

	localparam int unsigned NS = 4;

	logic [NS-1:0] v;
	logic [NS:0]   en;

	side_t      side_s1, side_s2;
	s32_t [2:0] rc_s1;
	s65_t [2:0] plo_s2, phi_s2;
	s32_t [2:0] o_s3, d_s3, tmin_s3, tmax_s3;
	logic       inside_s3;
	bound_t     bound_s4;

	s32_t [2:0] rc_d;
	s32_t [2:0] tmin_d, tmax_d;
	s32_t       t0, t1;
	s32_t       near_d, far_d;

	assign in_ready = en[0];

	always_comb begin
		en[NS] = out_ready;
		for (int k = NS - 1; k >= 0; k--) begin
			en[k] = !v[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v <= '0;
		end else begin
			if (en[0]) v[0] <= in_valid;
			for (int k = 1; k < NS; k++) begin
				if (en[k]) begin
					v[k] <= v[k-1];
				end
			end
		end
	end

	// signed, saturated reciprocal from the quotient
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (lanes[i].zero) begin
				rc_d[i] = S32_MAX;
			end else if (!lanes[i].neg) begin
				rc_d[i] = (quo[i].quo > NQ'(S32_MAX)) ? S32_MAX : s32_t'(quo[i].quo[31:0]);
			end else begin
				rc_d[i] = (quo[i].quo > NQ'(33'h0_8000_0000)) ? S32_MIN
					: s32_t'(-quo[i].quo[31:0]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			rc_s1   <= rc_d;
			side_s1 <= side;
		end
	end

	// slab products
	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int i = 0; i < 3; i++) begin
				plo_s2[i] <= s65_t'(side_s1.dlo[i]) * s65_t'(rc_s1[i]);
				phi_s2[i] <= s65_t'(side_s1.dhi[i]) * s65_t'(rc_s1[i]);
			end
			side_s2 <= side_s1;
		end
	end

	// floor shift, saturate, order per axis
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			t0 = sat32(plo_s2[i] >>> 16);
			t1 = sat32(phi_s2[i] >>> 16);
			tmin_d[i] = (t0 < t1) ? t0 : t1;
			tmax_d[i] = (t0 > t1) ? t0 : t1;
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			tmin_s3   <= tmin_d;
			tmax_s3   <= tmax_d;
			o_s3      <= side_s2.o;
			d_s3      <= side_s2.d;
			inside_s3 <= side_s2.in_box;
		end
	end

	// near is the largest minimum, far the smallest maximum
	always_comb begin
		near_d = tmin_s3[0];
		far_d  = tmax_s3[0];
		for (int i = 1; i < 3; i++) begin
			if (tmin_s3[i] > near_d) near_d = tmin_s3[i];
			if (tmax_s3[i] < far_d)  far_d  = tmax_s3[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			bound_s4.o      <= o_s3;
			bound_s4.d      <= d_s3;
			bound_s4.in_box <= inside_s3;
			bound_s4.nearb  <= near_d;
			bound_s4.farb   <= far_d;
		end
	end

	assign out_valid = v[NS-1];
	assign bound     = bound_s4;
endmodule

### design/rbsi_point.sv
// Back stages: hit test, entry distance, entry point products and sums.
// Depends on rbsi_pkg.
module rbsi_point (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  rbsi_pkg::bound_t            bound,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        hit,
	output rbsi_pkg::s32_t              distance,
	output rbsi_pkg::s32_t [2:0]        point
);
	import rbsi_pkg::*;

	logic [1:0] v;
	logic [2:0] en;

	s64_t [2:0] prod_s1;
	s32_t [2:0] o_s1;
	logic       hit_s1;
	s32_t       dist_s1;
	logic       hit_s2;
	s32_t       dist_s2;
	s32_t [2:0] pt_s2;
	s32_t [2:0] pt_d;
	s65_t       acc;

	assign en[2]    = out_ready;
	assign en[1]    = !v[1] || en[2];
	assign en[0]    = !v[0] || en[1];
	assign in_ready = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v <= '0;
		end else begin
			if (en[0]) v[0] <= in_valid;
			if (en[1]) v[1] <= v[0];
		end
	end

	// hit, distance and direction times near
	always_ff @(posedge clk) begin
		if (en[0]) begin
			hit_s1  <= (bound.farb >= 0) && (bound.nearb <= bound.farb);
			dist_s1 <= bound.in_box ? neg32(bound.nearb) : bound.nearb;
			o_s1    <= bound.o;
			for (int i = 0; i < 3; i++) begin
				prod_s1[i] <= s64_t'(bound.d[i]) * s64_t'(bound.nearb);
			end
		end
	end

	// origin plus product, floor shift, saturate
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			acc     = (s65_t'(o_s1[i]) <<< 16) + s65_t'(prod_s1[i]);
			pt_d[i] = sat32(acc >>> 16);
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			hit_s2  <= hit_s1;
			dist_s2 <= dist_s1;
			pt_s2   <= pt_d;
		end
	end

	assign out_valid = v[1];
	assign hit       = hit_s2;
	assign distance  = dist_s2;
	assign point     = pt_s2;
endmodule

### design/ray_box_slab_intersect.sv
// Ray versus axis-aligned box test by the slab method in signed Q16.16. One word
// (ray plus box) is taken every clock while the output is not stalled, and one
// result word leaves per input word, in order. The pipeline has one set-up stage,
// nine stages of the pipelined reciprocal divider (four quotient bits each), four
// slab stages and two point stages. Every stage has its own valid bit, so bubbles
// are squeezed out and a stall on the output holds all words without loss.
module ray_box_slab_intersect (
	input  logic        clk,
	input  logic        arst_n,
	rbsi_in_if.sink     rays,
	rbsi_out_if.source  results
);
	import rbsi_pkg::*;

	logic            p_v, p_r, r_v, r_r, s_v, s_r;
	side_t           p_side, r_side;
	lane_t [2:0]     p_lanes, r_lanes;
	div_t  [2:0]     r_quo;
	bound_t          s_bound;
	s32_t  [2:0]     o, d, lo, hi, pt;
	s32_t            entry_dist;

	assign o  = {rays.origin_z, rays.origin_y, rays.origin_x};
	assign d  = {rays.dir_z, rays.dir_y, rays.dir_x};
	assign lo = {rays.box_min_z, rays.box_min_y, rays.box_min_x};
	assign hi = {rays.box_max_z, rays.box_max_y, rays.box_max_x};

	rbsi_prep u_prep (
		.clk, .arst_n,
		.in_valid (rays.valid), .in_ready (rays.ready),
		.o, .d, .lo, .hi,
		.out_valid (p_v), .out_ready (p_r),
		.side (p_side), .lanes (p_lanes)
	);

	rbsi_recip u_recip (
		.clk, .arst_n,
		.in_valid (p_v), .in_ready (p_r),
		.side_in (p_side), .lanes_in (p_lanes),
		.out_valid (r_v), .out_ready (r_r),
		.side_out (r_side), .lanes_out (r_lanes), .quo_out (r_quo)
	);

	rbsi_slab u_slab (
		.clk, .arst_n,
		.in_valid (r_v), .in_ready (r_r),
		.side (r_side), .lanes (r_lanes), .quo (r_quo),
		.out_valid (s_v), .out_ready (s_r),
		.bound (s_bound)
	);

	rbsi_point u_point (
		.clk, .arst_n,
		.in_valid (s_v), .in_ready (s_r),
		.bound (s_bound),
		.out_valid (results.valid), .out_ready (results.ready),
		.hit (results.hit), .distance (entry_dist), .point (pt)
	);

	assign results.distance = entry_dist;
	assign results.point_x  = pt[0];
	assign results.point_y  = pt[1];
	assign results.point_z  = pt[2];
endmodule
